>>> rtl/ola_pkg.sv
package ola_pkg;

  // Default geometry of the list
  localparam int DEPTH_DEF   = 64;
  localparam int DATA_W_DEF  = 32;

  // Widest position field that any legal depth can need (depth up to 1024)
  localparam int DEPTH_MAX   = 1024;
  localparam int POS_MAX_W   = $clog2(DEPTH_MAX + 1);

  // Command codes on the input channel
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_DELVAL = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_REFUSED = 2'd1;
  localparam logic [1:0] STAT_RANGE   = 2'd2;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_COMPACT
  } state_t;

  // Operation applied by every cell
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_t;

  // Broadcast from the controller to the row of cells
  typedef struct packed {
    cell_op_t               op;
    logic                   keep;
    logic [POS_MAX_W-1:0]   pos;
  } cell_ctrl_t;

endpackage

>>> rtl/ordered_list_insert_delete.sv
// Insert and delete at position: result registered in the cycle after the input
//   transfer, one command per cycle sustained while the output is not stalled.
// Delete by value: the row of cells rotates once per held entry, and the result
//   is registered as the rotation ends; the next transfer follows it.
// Reset (synchronous, rst_n low) clears the entry count, controller and output
//   valid; the cell contents are not cleared and no clearing pass runs.
module ordered_list_insert_delete
  import ola_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_W_DEF,
  parameter int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [CNT_W-1:0]   in_position,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [CNT_W-1:0]   out_count,
  output logic               out_is_empty,
  output logic               out_is_full
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      steps_r, steps_nxt;
  logic [DATA_WIDTH-1:0] value_r, value_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_status_r, out_status_nxt;
  logic [CNT_W-1:0]      out_count_r, out_count_nxt;

  logic                  in_fire;
  logic                  out_fire;
  logic [63:0]           value_ext;
  logic [DATA_WIDTH-1:0] in_word;
  logic [DATA_WIDTH-1:0] cell_word;
  logic                  head_keep;
  cell_ctrl_t            ctrl;
  logic [DATA_WIDTH-1:0] data_w [DEPTH];

  // Handshake
  assign out_fire = out_valid_r & ~out_stall;
  assign in_stall = (state_r != ST_IDLE) | (out_valid_r & out_stall);
  assign in_fire  = in_valid & ~in_stall;

  // Stored words are the sign-extended input cut to DATA_WIDTH bits
  assign value_ext = {{32{in_value[31]}}, in_value};
  assign in_word   = value_ext[DATA_WIDTH-1:0];
  assign head_keep = (data_w[0] != value_r);

  // Controller: decode, status, rotation sequencing
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    steps_nxt      = steps_r;
    value_nxt      = value_r;
    out_valid_nxt  = out_valid_r & ~out_fire;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    ctrl.op        = CELL_HOLD;
    ctrl.keep      = 1'b0;
    ctrl.pos       = POS_MAX_W'(in_position);
    cell_word      = in_word;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_RANGE;
          out_count_nxt  = count_r;
          unique case (in_cmd)
            CMD_INSERT: begin
              if (count_r == FULL_CNT) begin
                out_status_nxt = STAT_REFUSED;
              end else if (in_position <= count_r) begin
                ctrl.op        = CELL_INS;
                count_nxt      = count_r + ONE;
                out_count_nxt  = count_r + ONE;
                out_status_nxt = STAT_DONE;
              end
            end
            CMD_DELETE: begin
              if (count_r == '0) begin
                out_status_nxt = STAT_REFUSED;
              end else if (in_position < count_r) begin
                ctrl.op        = CELL_DEL;
                count_nxt      = count_r - ONE;
                out_count_nxt  = count_r - ONE;
                out_status_nxt = STAT_DONE;
              end
            end
            CMD_DELVAL: begin
              if (count_r == '0) begin
                out_status_nxt = STAT_REFUSED;
              end else begin
                // result comes when the rotation ends
                out_valid_nxt = 1'b0;
                value_nxt     = in_word;
                steps_nxt     = count_r;
                state_nxt     = ST_COMPACT;
              end
            end
            default: out_status_nxt = STAT_RANGE;
          endcase
        end
      end
      ST_COMPACT: begin
        // pop the head, shift the row down, push a kept head at the tail
        ctrl.op   = CELL_ROT;
        ctrl.keep = head_keep;
        ctrl.pos  = POS_MAX_W'(count_r - ONE);
        cell_word = data_w[0];
        if (!head_keep) begin
          count_nxt = count_r - ONE;
        end
        steps_nxt = steps_r - ONE;
        if (steps_r == ONE) begin
          state_nxt      = ST_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_DONE;
          out_count_nxt  = count_nxt;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    value_r      <= value_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Row of cells; each sees its neighbors (zero beyond either end) and the broadcast command
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = data_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = data_w[g+1];
    end
    ola_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX        (g)
    ) u_cell (
      .clk     (clk),
      .left_i  (left_w),
      .right_i (right_w),
      .word_i  (cell_word),
      .ctrl_i  (ctrl),
      .data_o  (data_w[g])
    );
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_count    = out_count_r;
  assign out_is_empty = (out_count_r == '0);
  assign out_is_full  = (out_count_r == FULL_CNT);

  // Checks
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (state_r == ST_IDLE))
    else $error("transfer accepted while compacting");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above depth");

  a_steps_cover: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMPACT) |-> ((steps_r != '0) && (count_r >= steps_r)))
    else $error("rotation length exceeds held entries");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && in_fire && (in_cmd == CMD_INSERT) && (count_r != FULL_CNT)
     && (in_position <= count_r)) |=> (count_r == $past(count_r) + ONE))
    else $error("accepted insert did not grow the list");

  a_compact_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_COMPACT) && (steps_r == ONE))
    |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("compaction end without result");

endmodule

>>> rtl/ola_cell.sv
module ola_cell
  import ola_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_W_DEF,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  input  logic [DATA_WIDTH-1:0] word_i,
  input  cell_ctrl_t            ctrl_i,
  output logic [DATA_WIDTH-1:0] data_o
);

  localparam logic [POS_MAX_W-1:0] MY_IDX = POS_MAX_W'(IDX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  // Local shift decision from the broadcast position
  always_comb begin
    data_nxt = data_r;
    case (ctrl_i.op)
      CELL_INS: begin
        if (MY_IDX > ctrl_i.pos) begin
          data_nxt = left_i;
        end else if (MY_IDX == ctrl_i.pos) begin
          data_nxt = word_i;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= ctrl_i.pos) begin
          data_nxt = right_i;
        end
      end
      // rotate: whole row moves down, a kept head lands at the tail
      CELL_ROT: begin
        if (ctrl_i.keep && (MY_IDX == ctrl_i.pos)) begin
          data_nxt = word_i;
        end else begin
          data_nxt = right_i;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule
